@@ rtl/ipv4p_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 dotted-decimal parser package
// Shared types and character constants for the parser, its core and channels.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [9:0] BYTE_LIMIT      = 10'd255;
  localparam logic [2:0] FIELD_MAX_CHARS = 3'd3;
  localparam logic [1:0] LAST_FIELD      = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LONG  = 2'd1,
    ST_FEW   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] address;
    status_t     status;
  } result_t;

endpackage : ipv4p_pkg
`default_nettype wire

@@ rtl/ipv4p_char_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one string character per request.
// ----------------------------------------------------------------------------
interface ipv4p_char_if;

  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);

endinterface : ipv4p_char_if
`default_nettype wire

@@ rtl/ipv4p_addr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Address result channel
// Valid/ready channel carrying the packed address and parse status.
// ----------------------------------------------------------------------------
interface ipv4p_addr_if
  import ipv4p_pkg::*;
();

  logic        valid;
  logic        ready;
  logic [31:0] address;
  status_t     status;

  modport source (output valid, output address, output status, input ready);
  modport sink   (input valid, input address, input status, output ready);

endinterface : ipv4p_addr_if
`default_nettype wire

@@ rtl/ipv4p_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 parser core
// Holds the per-string parse state and updates it by one character per
// advance; forms the packed address and status when the terminator arrives.
// ----------------------------------------------------------------------------
module ipv4p_core
  import ipv4p_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance_i,
  input  wire logic [7:0] char_i,
  input  wire logic       byte_order_i,
  output result_t         result_o
);

  logic [1:0]  field_index_r,  field_index_nxt;
  logic [2:0]  field_length_r, field_length_nxt;
  logic [9:0]  field_value_r,  field_value_nxt;
  logic        digits_ended_r, digits_ended_nxt;
  logic [23:0] done_bytes_r,   done_bytes_nxt;
  logic        length_fault_r, length_fault_nxt;
  logic        range_fault_r,  range_fault_nxt;

  logic        is_digit;
  logic [7:0]  digit_full;
  logic [9:0]  value_times_ten;
  logic [31:0] host_addr;

  // Classify the character and form the next accumulated value
  always_comb begin
    is_digit        = char_i inside {[CHAR_ZERO:CHAR_NINE]};
    digit_full      = char_i - CHAR_ZERO;
    value_times_ten = (field_value_r << 3) + (field_value_r << 1);
  end

  // Next parse state for the character at hand
  always_comb begin
    field_index_nxt  = field_index_r;
    field_length_nxt = field_length_r;
    field_value_nxt  = field_value_r;
    digits_ended_nxt = digits_ended_r;
    done_bytes_nxt   = done_bytes_r;
    length_fault_nxt = length_fault_r;
    range_fault_nxt  = range_fault_r;
    if (char_i == CHAR_NUL) begin
      // Terminator: start over for the next string
      field_index_nxt  = '0;
      field_length_nxt = '0;
      field_value_nxt  = '0;
      digits_ended_nxt = 1'b0;
      done_bytes_nxt   = '0;
      length_fault_nxt = 1'b0;
      range_fault_nxt  = 1'b0;
    end else if (char_i == CHAR_DOT && field_index_r != LAST_FIELD) begin
      // Close the field and shift its low byte in
      range_fault_nxt  = range_fault_r | (field_value_r > BYTE_LIMIT);
      done_bytes_nxt   = {done_bytes_r[15:0], field_value_r[7:0]};
      field_index_nxt  = field_index_r + 2'd1;
      field_length_nxt = '0;
      field_value_nxt  = '0;
      digits_ended_nxt = 1'b0;
    end else if (field_length_r >= FIELD_MAX_CHARS) begin
      // Overlong field: flag and drop the character
      length_fault_nxt = 1'b1;
    end else begin
      field_length_nxt = field_length_r + 3'd1;
      if (is_digit) begin
        if (!digits_ended_r) begin
          field_value_nxt = value_times_ten + {6'd0, digit_full[3:0]};
        end
      end else begin
        digits_ended_nxt = 1'b1;
      end
    end
  end

  // Result for a terminator arriving now
  always_comb begin
    host_addr         = {done_bytes_r, field_value_r[7:0]};
    result_o.address  = '0;
    if (length_fault_r) begin
      result_o.status = ST_LONG;
    end else if (field_index_r != LAST_FIELD) begin
      result_o.status = ST_FEW;
    end else if (range_fault_r || field_value_r > BYTE_LIMIT) begin
      result_o.status = ST_RANGE;
    end else begin
      result_o.status = ST_OK;
      if (byte_order_i) begin
        result_o.address = {host_addr[7:0], host_addr[15:8],
                            host_addr[23:16], host_addr[31:24]};
      end else begin
        result_o.address = host_addr;
      end
    end
  end

  // Hold parse state; advance on each processed character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_index_r  <= '0;
      field_length_r <= '0;
      field_value_r  <= '0;
      digits_ended_r <= 1'b0;
      done_bytes_r   <= '0;
      length_fault_r <= 1'b0;
      range_fault_r  <= 1'b0;
    end else if (advance_i) begin
      field_index_r  <= field_index_nxt;
      field_length_r <= field_length_nxt;
      field_value_r  <= field_value_nxt;
      digits_ended_r <= digits_ended_nxt;
      done_bytes_r   <= done_bytes_nxt;
      length_fault_r <= length_fault_nxt;
      range_fault_r  <= range_fault_nxt;
    end
  end

endmodule : ipv4p_core
`default_nettype wire

@@ rtl/ipv4_dotted_decimal_parser_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 dotted-decimal parser
// Parses a NUL-terminated dotted-decimal string into a 32-bit address.
// ----------------------------------------------------------------------------
// Send the string one character per request on in_ch, ending with NUL (0).
// Each character is registered, then folded into the parse state. The NUL
// produces one request on out_ch with the packed address and a status (0 ok,
// 1 field too long, 2 too few fields, 3 value over 255; the address is 0
// unless ok). A new character is taken every cycle while no NUL is stalled.
// The accepted NUL passes from the input register to the result register,
// where out_ch can take the result. The single result register sets the pace
// only while a result waits: a further NUL stalls until out_ch takes the
// earlier one. Set the byte order with cfg_we and cfg_wdata (0: first field
// in bits 31..24, 1: first field in bits 7..0), only while the block is idle.
module ipv4_dotted_decimal_parser_top
  import ipv4p_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  ipv4p_char_if.sink  in_ch,
  ipv4p_addr_if.source out_ch
);

  logic       byte_order_r;
  logic       char_valid_r;
  logic [7:0] char_r;
  logic       out_valid_r;
  result_t    out_result_r;
  result_t    core_result;
  logic       out_free;
  logic       advance;
  logic       is_term;

  // Stage control: a non-terminator always moves on; a terminator needs room
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_term  = (char_r == CHAR_NUL);
  assign advance  = char_valid_r && (!is_term || out_free);
  assign in_ch.ready = !char_valid_r || advance;

  // Hold the byte order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= 1'b0;
    end else if (cfg_we) begin
      byte_order_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      char_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      char_r <= in_ch.character;
    end
  end

  ipv4p_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance_i    (advance),
    .char_i       (char_r),
    .byte_order_i (byte_order_r),
    .result_o     (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && is_term;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && is_term) begin
      out_result_r <= core_result;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.address = out_result_r.address;
  assign out_ch.status  = out_result_r.status;

  // A failed parse never shows an address
  a_addr_zero_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.address == 32'd0)
    else $error("nonzero address with fault status");

  // A processed terminator yields a result in the next cycle
  a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_term |=> out_valid_r)
    else $error("terminator processed without result");

  // A terminator blocked by a waiting result stays in the input register
  a_term_held: assert property (@(posedge clk) disable iff (!rst_n)
    char_valid_r && is_term && !out_free |=> char_valid_r && $stable(char_r))
    else $error("blocked terminator lost");

endmodule : ipv4_dotted_decimal_parser_top
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dotted-decimal IPv4 parser testbench
// Streams NUL-terminated strings one character per request into the parser.
// A cycle-free predictor works out each expected address and status. Strings
// are directed cases first, then random addresses, some well-formed and many
// broken or noisy, under both byte orders, random idling on both channels
// and one long result-side hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import ipv4p_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 10;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  ipv4p_char_if char_ch ();
  ipv4p_addr_if addr_ch ();

  ipv4_dotted_decimal_parser_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (char_ch),
    .out_ch    (addr_ch)
  );

  // Stimulus and expectation stores
  logic [7:0] pending_chars[$];
  result_t    expected_addrs[$];

  // Predictor copy of the parse state and the byte order register
  logic       swap_order;
  logic [1:0] field_idx;
  logic [2:0] field_len;
  logic [9:0] field_val;
  logic       digits_over;
  logic [23:0] closed_bytes;
  logic       long_seen;
  logic       over_seen;

  // Run control and bookkeeping
  bit src_idle_on;
  bit sink_idle_on;
  bit hold_armed;
  int src_gap;
  int sink_gap;
  int hold_left;
  int idle_cycles;
  int error_count;
  int chars_sent;
  int addrs_checked;
  int ok_addrs;
  int order_writes;

  // Clock and reset
  always #HALF_PERIOD clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_parse_state();
    field_idx    = '0;
    field_len    = '0;
    field_val    = '0;
    digits_over  = 1'b0;
    closed_bytes = '0;
    long_seen    = 1'b0;
    over_seen    = 1'b0;
  endtask

  // Fold one accepted character into the predicted state; queue a result at NUL
  task automatic parse_char(input logic [7:0] ch);
    result_t res;
    if (ch == CHAR_NUL) begin
      res.address = '0;
      if (long_seen) begin
        res.status = ST_LONG;
      end else if (field_idx < LAST_FIELD) begin
        res.status = ST_FEW;
      end else if (over_seen || field_val > BYTE_LIMIT) begin
        res.status = ST_RANGE;
      end else begin
        res.status  = ST_OK;
        res.address = {closed_bytes, field_val[7:0]};
        if (swap_order) begin
          res.address = {res.address[7:0], res.address[15:8],
                         res.address[23:16], res.address[31:24]};
        end
      end
      expected_addrs.push_back(res);
      clear_parse_state();
    end else if (ch == CHAR_DOT && field_idx < LAST_FIELD) begin
      if (field_val > BYTE_LIMIT) over_seen = 1'b1;
      closed_bytes = {closed_bytes[15:0], field_val[7:0]};
      field_idx    = field_idx + 2'd1;
      field_len    = '0;
      field_val    = '0;
      digits_over  = 1'b0;
    end else if (field_len >= FIELD_MAX_CHARS) begin
      // drop extra characters of a long field, just flag it
      long_seen = 1'b1;
    end else begin
      field_len = field_len + 3'd1;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        if (!digits_over) field_val = 10'(field_val * 10 + (ch - CHAR_ZERO));
      end else begin
        digits_over = 1'b1;
      end
    end
  endtask

  // Character driver: hold a stalled request, else idle or advance the queue
  always @(posedge clk) begin : drive_chars
    if (!rst_n) begin
      char_ch.valid     <= 1'b0;
      char_ch.character <= '0;
      src_gap = 0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        parse_char(char_ch.character);
        chars_sent++;
      end
      if (char_ch.valid && !char_ch.ready) begin
        // hold the offered character
      end else if (src_gap > 0) begin
        src_gap--;
        char_ch.valid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        char_ch.valid     <= 1'b1;
        char_ch.character <= pending_chars.pop_front();
        src_gap = src_idle_on ? pick_gap() : 0;
      end else begin
        char_ch.valid <= 1'b0;
      end
    end
  end

  // Address monitor: check each accepted result, then pick the next ready
  always @(posedge clk) begin : collect_addrs
    result_t want;
    if (!rst_n) begin
      addr_ch.ready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
    end else begin
      if (addr_ch.valid && addr_ch.ready) begin
        if (expected_addrs.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: address %h, status %0d", $time,
                   addr_ch.address, addr_ch.status);
        end else begin
          want = expected_addrs.pop_front();
          addrs_checked++;
          if (want.status == ST_OK) ok_addrs++;
          if (addr_ch.address !== want.address) begin
            error_count++;
            $display("%0t: address mismatch: expected %h, actual %h", $time,
                     want.address, addr_ch.address);
          end
          if (addr_ch.status !== want.status) begin
            error_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     want.status, addr_ch.status);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        addr_ch.ready <= 1'b0;
      end else if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
        addr_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        addr_ch.ready <= 1'b0;
      end else begin
        addr_ch.ready <= 1'b1;
        sink_gap = sink_idle_on ? pick_gap() : 0;
      end
    end
  end

  // Watchdog: end the run when no request moves for too long
  always @(posedge clk) begin : watch_progress
    if (rst_n) begin
      if ((char_ch.valid && char_ch.ready) || (addr_ch.valid && addr_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_string(input string text);
    for (int i = 0; i < text.len(); i++) pending_chars.push_back(text[i]);
    pending_chars.push_back(CHAR_NUL);
  endtask

  function automatic logic [7:0] pick_odd_char();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return "+";
      1: return "-";
      2: return " ";
      3: return 8'h09;
      4: return 8'($urandom_range("a", "z"));
      5, 6: return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
    endcase
  endfunction

  // One field: mostly a byte value, sometimes too big, empty or garbled
  task automatic push_field();
    int r;
    string digits;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      digits = $sformatf("%0d", $urandom_range(0, 255));
      if (r < 5) digits = $sformatf("%03d", $urandom_range(0, 255));
    end else if (r < 77) begin
      digits = $sformatf("%0d", $urandom_range(256, 999));
    end else if (r < 83) begin
      digits = "";
    end else begin
      digits = "";
      repeat ($urandom_range(1, 6)) pending_chars.push_back(pick_odd_char());
    end
    for (int i = 0; i < digits.len(); i++) pending_chars.push_back(digits[i]);
  endtask

  // One string: mostly four fields, some short ones, some pure noise
  task automatic push_random_string();
    int kind;
    int n_fields;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(0, 10)) pending_chars.push_back(8'($urandom_range(1, 255)));
    end else begin
      n_fields = (kind < 24) ? $urandom_range(1, 3) : 4;
      for (int f = 0; f < n_fields; f++) begin
        if (f > 0) pending_chars.push_back(CHAR_DOT);
        push_field();
      end
      if (kind >= 92) begin
        repeat ($urandom_range(1, 4)) pending_chars.push_back(pick_odd_char());
      end
    end
    pending_chars.push_back(CHAR_NUL);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_chars.size() != 0 || char_ch.valid || expected_addrs.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_byte_order(input logic order);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= order;
    @(posedge clk);
    cfg_we    <= 1'b0;
    swap_order = order;
    order_writes++;
  endtask

  task automatic run_random_phase(input logic order, input int n_chars,
                                  input bit idle_on, input bit with_hold);
    int queued;
    wait_idle();
    set_byte_order(order);
    @(negedge clk);
    src_idle_on  = idle_on;
    sink_idle_on = idle_on;
    queued = 0;
    while (queued < n_chars) begin
      queued -= pending_chars.size();
      push_random_string();
      queued += pending_chars.size();
    end
    if (with_hold) hold_armed = 1'b1;
  endtask

  // Main sequence
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    char_ch.valid = 1'b0;
    char_ch.character = '0;
    addr_ch.ready = 1'b0;
    swap_order = 1'b0;
    clear_parse_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_byte_order(1'b0);

    // Directed strings: odd field content, long field, too few fields, range
    @(negedge clk);
    push_string("255.-7.a1.9.\377");
    push_string("1234");
    push_string("..");
    push_string("...999");

    run_random_phase(1'b1, 300, 1'b1, 1'b0);
    run_random_phase(1'b0, 300, 1'b1, 1'b1);
    run_random_phase(1'b1, 250, 1'b0, 1'b0);
    run_random_phase(1'b0, 150, 1'b1, 1'b0);

    // Drain and let the pipeline settle
    @(negedge clk);
    while (pending_chars.size() != 0 || char_ch.valid || expected_addrs.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_addrs.size() != 0) error_count++;

    $display("Sent %0d characters, checked %0d addresses (%0d well-formed)",
             chars_sent, addrs_checked, ok_addrs);
    $display("over %0d byte-order writes, with idling and one long result hold-off",
             order_writes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : testbench
